// ===== rtl/csbp_pkg.sv =====
// csbp_pkg: shared types and constants for the clock-sweep buffer pool tag table
// used by csbp_cell and clock_sweep_buffer_pool_unit
// no dependencies
package csbp_pkg;

  localparam int NUM_SLOTS_DEF = 64;

  localparam int REQ_W    = 2;
  localparam int TABLE_W  = 32;
  localparam int PAGE_W   = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 8;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0]   SLOTS_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] USE_MAX     = 8'd255;
  localparam logic [COUNT_W-1:0] USE_INSTALL = 8'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_GRAB    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_NOFREE = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FREECHK,
    ST_SWEEP
  } state_t;

  // what each cell presents to the pick tree
  typedef enum logic [1:0] {
    SEL_MATCH,
    SEL_FREE,
    SEL_TAKEN
  } sel_mode_t;

  typedef struct packed {
    sel_mode_t mode;
    logic      touch;
    logic      unpin;
    logic      install;
    logic      load_hand;
    logic      sweep;
  } cell_cmd_t;

endpackage

// ===== rtl/clock_sweep_buffer_pool_unit.sv =====
// clock_sweep_buffer_pool_unit: buffer pool tag table with clock-sweep replacement
// depends on csbp_pkg, csbp_cell, csbp_pick_tree
//
// Usage:
//   A request (req_type, table_id, page_id) transfers at a clock edge with start high
//   and busy low. Each request except type 3 gives one result on status, slot_index,
//   evicted_valid and evicted_page, marked by done for exactly one cycle; the receiver
//   cannot stall, so results must be taken when done is high. Type 3 is dropped.
//   The user must write slots_in_use through cfg_we / cfg_wdata only while the block
//   is idle; the block itself does not enforce this.
//   Flow, with a pick tree of L = clog2(NUM_SLOTS) registered levels:
//   - lookup and release: a search through the tree, then the decision and the result.
//   - grab: a free-slot check through the tree, then the hand moves one cell per
//     cycle along the full row of NUM_SLOTS cells (inactive cells are passed too),
//     then the chosen slot is read back through the tree. The hand may make several
//     full turns. With every active slot pinned the grab ends after the free-slot
//     check.
//   busy is high from the transfer until the result is issued; a new request can
//   transfer in the cycle that done is high.
//   Reset (synchronous, rst high) empties every slot, homes the hand to slot 0 and
//   sets slots_in_use to 64.
module clock_sweep_buffer_pool_unit #(
  parameter int NUM_SLOTS = csbp_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [csbp_pkg::REQ_W-1:0]     req_type,
  input  logic [csbp_pkg::TABLE_W-1:0]   table_id,
  input  logic [csbp_pkg::PAGE_W-1:0]    page_id,
  input  logic                           cfg_we,
  input  logic [csbp_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                           done,
  output logic [csbp_pkg::STATUS_W-1:0]  status,
  output logic [csbp_pkg::SLOT_W-1:0]    slot_index,
  output logic                           evicted_valid,
  output logic [csbp_pkg::PAGE_W-1:0]    evicted_page
);

  localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW  = $clog2(NUM_SLOTS + 1);
  localparam int MW  = (CW > csbp_pkg::CFG_W) ? CW : csbp_pkg::CFG_W;
  localparam int XW  = (IW > csbp_pkg::SLOT_W) ? IW : csbp_pkg::SLOT_W;
  localparam int WW  = $clog2(IW + 1);
  localparam int DW  = csbp_pkg::PAGE_W + 1;

  // request and configuration registers
  csbp_pkg::req_t               req_q;
  logic [csbp_pkg::TABLE_W-1:0] tbl_q;
  logic [csbp_pkg::PAGE_W-1:0]  pg_q;
  logic [csbp_pkg::CFG_W-1:0]   slots_in_use;
  logic [IW-1:0]                clock_hand;
  logic [IW-1:0]                clock_hand_next;

  csbp_pkg::state_t state;
  csbp_pkg::state_t state_next;
  logic [WW-1:0]    wait_cnt;
  logic [WW-1:0]    wait_cnt_next;

  logic                accept;
  logic [MW-1:0]       siu_w;
  logic [CW-1:0]       n_act;
  logic [IW-1:0]       hand_start;
  logic                tree_ready;
  logic                finish;
  logic                hand_upd;
  csbp_pkg::cell_cmd_t cmd;
  logic [IW-1:0]       cmd_idx;

  logic [csbp_pkg::STATUS_W-1:0] res_status;
  logic [IW-1:0]                 res_idx;
  logic                          res_ev;
  logic [csbp_pkg::PAGE_W-1:0]   res_page;
  logic [XW-1:0]                 res_idx_w;

  logic [NUM_SLOTS-1:0] sel;
  logic [NUM_SLOTS-1:0] token_out;
  logic [DW-1:0]        leaf_data [NUM_SLOTS];
  logic                 tree_any;
  logic [IW-1:0]        tree_idx;
  logic [DW-1:0]        tree_data;

  assign accept = start && !busy;
  assign busy   = state != csbp_pkg::ST_IDLE;

  // effective slot count, clamped to 1 .. NUM_SLOTS
  always_comb begin
    siu_w = MW'(slots_in_use);
    if (siu_w == '0) begin
      n_act = CW'(1);
    end else if (siu_w > MW'(NUM_SLOTS)) begin
      n_act = CW'(NUM_SLOTS);
    end else begin
      n_act = CW'(siu_w);
    end
  end

  assign hand_start = (CW'(clock_hand) < n_act) ? clock_hand : '0;
  assign tree_ready = wait_cnt == WW'(IW);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      csbp_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type)
            csbp_pkg::REQ_LOOKUP,
            csbp_pkg::REQ_RELEASE: state_next = csbp_pkg::ST_SEARCH;
            csbp_pkg::REQ_GRAB:    state_next = csbp_pkg::ST_FREECHK;
            default:               state_next = csbp_pkg::ST_IDLE;
          endcase
        end
      end
      csbp_pkg::ST_SEARCH: begin
        if (tree_ready) state_next = csbp_pkg::ST_IDLE;
      end
      csbp_pkg::ST_FREECHK: begin
        if (tree_ready) begin
          state_next = tree_any ? csbp_pkg::ST_SWEEP : csbp_pkg::ST_IDLE;
        end
      end
      csbp_pkg::ST_SWEEP: begin
        if (tree_ready && tree_any) state_next = csbp_pkg::ST_IDLE;
      end
      default: state_next = csbp_pkg::ST_IDLE;
    endcase
  end

  // tree wait counter restarts on every state change
  always_comb begin
    if (state_next != state) begin
      wait_cnt_next = '0;
    end else if (!tree_ready) begin
      wait_cnt_next = wait_cnt + 1'b1;
    end else begin
      wait_cnt_next = wait_cnt;
    end
  end

  // outputs of the state machine
  always_comb begin
    cmd             = '0;
    cmd.mode        = csbp_pkg::SEL_MATCH;
    cmd_idx         = tree_idx;
    finish          = 1'b0;
    hand_upd        = 1'b0;
    res_status      = csbp_pkg::STAT_OK;
    res_idx         = '0;
    res_ev          = 1'b0;
    res_page        = '0;
    clock_hand_next = clock_hand;
    case (state)
      csbp_pkg::ST_IDLE: begin
        cmd.mode = csbp_pkg::SEL_MATCH;
      end
      csbp_pkg::ST_SEARCH: begin
        cmd.mode = csbp_pkg::SEL_MATCH;
        if (tree_ready) begin
          finish    = 1'b1;
          cmd.touch = tree_any;
          cmd.unpin = req_q == csbp_pkg::REQ_RELEASE;
          if (tree_any) begin
            res_idx = tree_idx;
          end else if (req_q == csbp_pkg::REQ_RELEASE) begin
            res_status = csbp_pkg::STAT_ABSENT;
          end else begin
            res_status = csbp_pkg::STAT_MISS;
          end
        end
      end
      csbp_pkg::ST_FREECHK: begin
        cmd.mode = csbp_pkg::SEL_FREE;
        cmd_idx  = hand_start;
        if (tree_ready) begin
          if (tree_any) begin
            cmd.load_hand = 1'b1;
          end else begin
            finish     = 1'b1;
            res_status = csbp_pkg::STAT_NOFREE;
          end
        end
      end
      csbp_pkg::ST_SWEEP: begin
        cmd.mode  = csbp_pkg::SEL_TAKEN;
        cmd.sweep = 1'b1;
        if (tree_ready && tree_any) begin
          finish      = 1'b1;
          hand_upd    = 1'b1;
          cmd.install = 1'b1;
          res_idx     = tree_idx;
          res_ev      = tree_data[DW-1];
          res_page    = tree_data[DW-1] ? tree_data[csbp_pkg::PAGE_W-1:0] : '0;
          // hand stops just past the granted slot
          if (CW'(tree_idx) + CW'(1) == n_act) begin
            clock_hand_next = '0;
          end else begin
            clock_hand_next = tree_idx + 1'b1;
          end
        end
      end
      default: begin
        cmd.mode = csbp_pkg::SEL_MATCH;
      end
    endcase
  end

  assign res_idx_w = XW'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= csbp_pkg::ST_IDLE;
      wait_cnt     <= '0;
      slots_in_use <= csbp_pkg::SLOTS_RESET;
      clock_hand   <= '0;
      done         <= 1'b0;
    end else begin
      state    <= state_next;
      wait_cnt <= wait_cnt_next;
      done     <= finish;
      if (cfg_we) begin
        slots_in_use <= cfg_wdata;
      end
      if (hand_upd) begin
        clock_hand <= clock_hand_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= csbp_pkg::req_t'(req_type);
      tbl_q <= table_id;
      pg_q  <= page_id;
    end
    if (finish) begin
      status        <= res_status;
      slot_index    <= res_idx_w[csbp_pkg::SLOT_W-1:0];
      evicted_valid <= res_ev;
      evicted_page  <= res_page;
    end
  end

  // row of slot cells; the hand token wraps from the last cell to the first
  genvar c;
  generate
    for (c = 0; c < NUM_SLOTS; c++) begin : g_cell
      logic                        cell_tnz;
      logic [csbp_pkg::PAGE_W-1:0] cell_page;

      csbp_cell #(
        .IDX (c),
        .IW  (IW),
        .CW  (CW)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .cmd_idx   (cmd_idx),
        .n_act     (n_act),
        .req_table (tbl_q),
        .req_page  (pg_q),
        .token_in  (token_out[(c + NUM_SLOTS - 1) % NUM_SLOTS]),
        .token_out (token_out[c]),
        .sel       (sel[c]),
        .tnz       (cell_tnz),
        .page      (cell_page)
      );

      assign leaf_data[c] = {cell_tnz, cell_page};
    end
  endgenerate

  csbp_pick_tree #(
    .N  (NUM_SLOTS),
    .IW (IW),
    .DW (DW)
  ) u_tree (
    .clk  (clk),
    .rst  (rst),
    .sel  (sel),
    .data (leaf_data),
    .any  (tree_any),
    .idx  (tree_idx),
    .dout (tree_data)
  );

endmodule

// ===== rtl/csbp_cell.sv =====
// csbp_cell: one buffer slot tag (table, page, pin, use count) with its share of the hand
// the hand token moves from each cell to the next one per sweep cycle
// depends on csbp_pkg
module csbp_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  csbp_pkg::cell_cmd_t           cmd,
  input  logic [IW-1:0]                 cmd_idx,
  input  logic [CW-1:0]                 n_act,
  input  logic [csbp_pkg::TABLE_W-1:0]  req_table,
  input  logic [csbp_pkg::PAGE_W-1:0]   req_page,
  input  logic                          token_in,
  output logic                          token_out,
  output logic                          sel,
  output logic                          tnz,
  output logic [csbp_pkg::PAGE_W-1:0]   page
);

  logic [csbp_pkg::TABLE_W-1:0] tbl;
  logic                         pinned;
  logic [csbp_pkg::COUNT_W-1:0] use_count;
  logic                         token;
  logic                         taken;

  logic active;
  logic is_tgt;
  logic match;
  logic free_here;

  assign active    = CW'(IDX) < n_act;
  assign is_tgt    = cmd_idx == IW'(IDX);
  assign match     = (tbl == req_table) && (page == req_page);
  assign free_here = !pinned && (use_count == '0);
  assign tnz       = tbl != '0;

  // inactive cells just pass the hand on
  assign token_out = token && !(active && free_here);

  always_comb begin
    case (cmd.mode)
      csbp_pkg::SEL_MATCH: sel = active && match;
      csbp_pkg::SEL_FREE:  sel = active && !pinned;
      csbp_pkg::SEL_TAKEN: sel = taken;
      default:             sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl       <= '0;
      page      <= '0;
      pinned    <= 1'b0;
      use_count <= '0;
      token     <= 1'b0;
      taken     <= 1'b0;
    end else begin
      if (cmd.touch && is_tgt) begin
        if (use_count != csbp_pkg::USE_MAX) begin
          use_count <= use_count + 1'b1;
        end
        pinned <= !cmd.unpin;
      end
      if (cmd.load_hand) begin
        token <= is_tgt;
      end else if (cmd.sweep) begin
        token <= token_in;
        if (token && active) begin
          if (free_here) begin
            taken <= 1'b1;
          end else if (use_count != '0) begin
            use_count <= use_count - 1'b1;
          end
        end
      end
      // install waits for the pick tree so the old page can be read out first
      if (cmd.install && taken) begin
        tbl       <= req_table;
        page      <= req_page;
        pinned    <= 1'b1;
        use_count <= csbp_pkg::USE_INSTALL;
        taken     <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/csbp_pick_tree.sv =====
// csbp_pick_tree: registered binary tree that finds the lowest selected cell
// and carries that cell's payload to the root, one level per cycle
// no dependencies
module csbp_pick_tree #(
  parameter int N  = 64,
  parameter int IW = 6,
  parameter int DW = 65
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [N-1:0]  sel,
  input  logic [DW-1:0] data [N],
  output logic          any,
  output logic [IW-1:0] idx,
  output logic [DW-1:0] dout
);

  localparam int P = 1 << IW;

  logic          leaf_v [P];
  logic [DW-1:0] leaf_d [P];

  logic          node_v [1:P-1];
  logic [IW-1:0] node_i [1:P-1];
  logic [DW-1:0] node_d [1:P-1];

  genvar j, k;
  generate
    for (j = 0; j < P; j++) begin : g_leaf
      if (j < N) begin : g_real
        assign leaf_v[j] = sel[j];
        assign leaf_d[j] = data[j];
      end else begin : g_pad
        assign leaf_v[j] = 1'b0;
        assign leaf_d[j] = '0;
      end
    end

    for (k = 1; k < P; k++) begin : g_node
      if (2 * k >= P) begin : g_bottom
        localparam int A = 2 * k - P;
        always_ff @(posedge clk) begin
          if (rst) begin
            node_v[k] <= 1'b0;
          end else begin
            node_v[k] <= leaf_v[A] || leaf_v[A+1];
          end
          if (leaf_v[A]) begin
            node_i[k] <= IW'(A);
            node_d[k] <= leaf_d[A];
          end else begin
            node_i[k] <= IW'(A + 1);
            node_d[k] <= leaf_d[A+1];
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          if (rst) begin
            node_v[k] <= 1'b0;
          end else begin
            node_v[k] <= node_v[2*k] || node_v[2*k+1];
          end
          // lower half wins
          if (node_v[2*k]) begin
            node_i[k] <= node_i[2*k];
            node_d[k] <= node_d[2*k];
          end else begin
            node_i[k] <= node_i[2*k+1];
            node_d[k] <= node_d[2*k+1];
          end
        end
      end
    end
  endgenerate

  assign any  = node_v[1];
  assign idx  = node_i[1];
  assign dout = node_d[1];

endmodule
